// ===== hw/rtl/aisbit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisbit_pkg
// Shared constants, operation codes and the controller command bundle.
// ----------------------------------------------------------------------------
package aisbit_pkg;

  // packet store geometry
  localparam int MAX_BITS    = 1024;
  localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int CNT_W       = $clog2(MAX_BITS + 1);

  // field widths
  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int FILL_W    = 8;
  localparam int POS_W     = 10;
  localparam int FCNT_W    = 6;
  localparam int FIELD_W   = 32;
  localparam int MIN_W     = 11;
  localparam int OCNT_W    = 11;
  localparam int CRC_W     = 16;
  localparam int MTYPE_W   = 6;
  localparam int RPT_W     = 2;
  localparam int SID_W     = 30;
  localparam int HDR_BITS  = MTYPE_W + RPT_W + SID_W;
  localparam int STEP_W    = 8;

  localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int LIM_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

  // field read window: a 32-bit field at any bit offset fits in five bytes
  localparam int WIN_BYTES = (FIELD_W + 7 + 7) / 8;
  localparam int WIN_W     = WIN_BYTES * 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 104;

  // crc-16 x.25, reflected
  localparam logic [CRC_W-1:0] CRC_POLY  = 16'h8408;
  localparam logic [CRC_W-1:0] CRC_START = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_GOOD  = 16'hF0B8;
  localparam int               CRC_BITS  = 16;

  localparam logic [MIN_W-1:0] MIN_GOOD_RESET = 11'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_BYTE = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_FILL = 3'd1;
  localparam logic [OP_W-1:0] OP_DISCARD  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ     = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

  // register map (word index taken from paddr[2])
  localparam logic REG_MIN_GOOD = 1'b0;

  typedef struct packed {
    logic       capture;       // latch input transaction fields
    logic       discard;       // drop trailing crc bits
    logic       clear;         // empty the packet
    logic       load_partial;  // latch current byte from store
    logic       put;           // append one bit
    logic       crc_en;        // advance crc with the same step
    logic       zero_fill;     // appended bit is zero
    logic       rd_field;      // store read address from field position
    logic       win_load;      // shift read byte into window
    logic       extract;       // form field value from window
    logic       load_result;   // capture result transaction
    logic [2:0] idx;           // bit or byte index of the step
  } aisbit_cmd_t;

endpackage

// ===== hw/rtl/aisbit_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisbit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aisbit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/aisbit_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisbit_dp
// Datapath: bit store, bit count, crc register, header shadow, field window.
// ----------------------------------------------------------------------------
module aisbit_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  aisbit_pkg::aisbit_cmd_t             cmd,
  input  logic [aisbit_pkg::BYTE_W-1:0]       in_byte,
  input  logic [aisbit_pkg::POS_W-1:0]        in_pos,
  input  logic [aisbit_pkg::FCNT_W-1:0]       in_cnt,
  input  logic [aisbit_pkg::MIN_W-1:0]        min_good_bits,
  output logic [aisbit_pkg::OUT_TDATA_W-1:0]  result_data
);

  localparam int CNT_W  = aisbit_pkg::CNT_W;
  localparam int ADDR_W = aisbit_pkg::ADDR_W;
  localparam int CMP_W  = aisbit_pkg::CMP_W;
  localparam int LIM_W  = aisbit_pkg::LIM_W;
  localparam int POS_W  = aisbit_pkg::POS_W;
  localparam int FW     = aisbit_pkg::FIELD_W;
  localparam int WIN_W  = aisbit_pkg::WIN_W;
  localparam int HB     = aisbit_pkg::HDR_BITS;
  localparam int MT_W   = aisbit_pkg::MTYPE_W;
  localparam int RP_W   = aisbit_pkg::RPT_W;
  localparam int SID_W  = aisbit_pkg::SID_W;
  localparam int PAD_W  = aisbit_pkg::OUT_TDATA_W - (aisbit_pkg::OCNT_W + aisbit_pkg::CRC_W
                          + 2 + FW + MT_W + RP_W + SID_W + 1);

  // captured transaction fields
  logic [7:0]                      byte_r;
  logic [POS_W-1:0]                pos_r;
  logic [aisbit_pkg::FCNT_W-1:0]   cnt_r;

  // packet state
  logic [CNT_W-1:0]                stored_bits;
  logic [aisbit_pkg::CRC_W-1:0]    crc;
  logic                            overflow;
  logic [HB-1:0]                   hdr;
  logic [7:0]                      partial;
  logic [WIN_W-1:0]                window;
  logic [FW-1:0]                   field_r;
  logic [aisbit_pkg::OUT_TDATA_W-1:0] result_r;

  // RAM port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;
  logic [7:0]        new_byte;

  logic                         full;
  logic                         put_val;
  logic                         crc_in;
  logic [aisbit_pkg::CRC_W-1:0] crc_step;
  logic [POS_W:0]               field_addr;

  logic [WIN_W-1:0]             shifted;
  logic signed [LIM_W-1:0]      lim;
  logic [FW-1:0]                rev;
  logic [FW-1:0]                field_next;

  logic [HB-1:0]                hv;
  logic [MT_W-1:0]              mtype;
  logic [RP_W-1:0]              rpt;
  logic [SID_W-1:0]             sid;
  logic                         too_short;
  logic                         crc_ok;

  aisbit_ram #(
    .WIDTH (8),
    .DEPTH (aisbit_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (new_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  // bit append
  always_comb begin
    full    = (stored_bits >= CNT_W'(aisbit_pkg::MAX_BITS));
    put_val = !cmd.zero_fill && byte_r[cmd.idx];
    new_byte = partial;
    new_byte[stored_bits[2:0]] = put_val;
    we      = cmd.put && !full;
    waddr   = ADDR_W'(stored_bits >> 3);
    field_addr = (POS_W+1)'(pos_r >> 3) + (POS_W+1)'(cmd.idx);
    raddr   = cmd.rd_field ? field_addr[ADDR_W-1:0] : ADDR_W'(stored_bits >> 3);
    // crc takes the byte msb first
    crc_in  = byte_r[3'd7 - cmd.idx];
    crc_step = (crc_in ^ crc[0]) ? ((crc >> 1) ^ aisbit_pkg::CRC_POLY) : (crc >> 1);
  end

  // field extraction: bits at or past the count read zero
  always_comb begin
    shifted = window >> pos_r[2:0];
    lim = $signed(LIM_W'(stored_bits)) - $signed(LIM_W'(pos_r));
    for (int i = 0; i < FW; i++) begin
      rev[FW-1-i] = shifted[i] && (lim > $signed(LIM_W'(i)));
    end
    field_next = rev >> (6'(FW) - cnt_r);
  end

  // header fields from the shadow register
  always_comb begin
    for (int i = 0; i < HB; i++) begin
      hv[i] = hdr[i] && (stored_bits > CNT_W'(i));
    end
    for (int i = 0; i < MT_W; i++) begin
      mtype[MT_W-1-i] = hv[i];
    end
    for (int i = 0; i < RP_W; i++) begin
      rpt[RP_W-1-i] = hv[MT_W+i];
    end
    for (int i = 0; i < SID_W; i++) begin
      sid[SID_W-1-i] = hv[MT_W+RP_W+i];
    end
    too_short = CMP_W'(stored_bits) < CMP_W'(min_good_bits);
    crc_ok    = (crc == aisbit_pkg::CRC_GOOD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_bits <= '0;
      crc         <= aisbit_pkg::CRC_START;
      overflow    <= 1'b0;
    end else begin
      if (cmd.put) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          stored_bits <= stored_bits + CNT_W'(1);
        end
        if (cmd.crc_en) begin
          crc <= crc_step;
        end
      end
      if (cmd.discard && crc != aisbit_pkg::CRC_START) begin
        stored_bits <= (stored_bits >= CNT_W'(aisbit_pkg::CRC_BITS))
                       ? stored_bits - CNT_W'(aisbit_pkg::CRC_BITS) : '0;
        crc <= aisbit_pkg::CRC_START;
      end
      if (cmd.clear) begin
        stored_bits <= '0;
        crc         <= aisbit_pkg::CRC_START;
        overflow    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r  <= in_byte;
      pos_r   <= in_pos;
      cnt_r   <= (in_cnt > 6'(FW)) ? 6'(FW) : in_cnt;
      field_r <= '0;
    end
    if (cmd.load_partial) begin
      partial <= rdata;
    end
    if (cmd.put && !full) begin
      partial <= (stored_bits[2:0] == 3'd7) ? 8'h00 : new_byte;
      if (stored_bits < CNT_W'(HB)) begin
        hdr[stored_bits[$clog2(HB)-1:0]] <= put_val;
      end
    end
    if (cmd.win_load) begin
      window <= {rdata, window[WIN_W-1:8]};
    end
    if (cmd.extract) begin
      field_r <= field_next;
    end
    if (cmd.load_result) begin
      result_r <= {PAD_W'(0), overflow, sid, rpt, mtype, field_r, too_short, crc_ok, crc,
                   aisbit_pkg::OCNT_W'(stored_bits)};
    end
  end

  assign result_data = result_r;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_bits <= CNT_W'(aisbit_pkg::MAX_BITS))
    else $error("bit count past capacity");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (stored_bits == '0) && (crc == aisbit_pkg::CRC_START) && !overflow)
    else $error("clear left packet state");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd.put && full |=> overflow)
    else $error("dropped bit not flagged");

endmodule

// ===== hw/rtl/aisbit_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aisbit_ctrl
// Controller: sequences bit steps, field reads and the result handshake.
// ----------------------------------------------------------------------------
module aisbit_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [aisbit_pkg::OP_W-1:0]     op,
  input  logic [aisbit_pkg::FILL_W-1:0]   fill,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output aisbit_pkg::aisbit_cmd_t         cmd
);

  localparam int STEP_W = aisbit_pkg::STEP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD_CUR = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_FRD    = 3'd4;
  localparam logic [2:0] S_FLAST  = 3'd5;
  localparam logic [2:0] S_FEXT   = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [STEP_W-1:0] limit, limit_next;
  logic              is_add, is_add_next;
  logic              out_valid, out_valid_next;

  always_comb begin
    state_next  = state;
    step_next   = step;
    limit_next  = limit;
    is_add_next = is_add;
    cmd         = '0;
    cmd.idx     = step[2:0];
    s_tready    = 1'b0;

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          step_next   = '0;
          unique case (op)
            aisbit_pkg::OP_ADD_BYTE: begin
              limit_next  = STEP_W'(8);
              is_add_next = 1'b1;
              state_next  = S_RD_CUR;
            end
            aisbit_pkg::OP_ADD_FILL: begin
              limit_next  = fill;
              is_add_next = 1'b0;
              state_next  = (fill == '0) ? S_RESULT : S_RD_CUR;
            end
            aisbit_pkg::OP_DISCARD: begin
              cmd.discard = 1'b1;
              state_next  = S_RESULT;
            end
            aisbit_pkg::OP_READ: begin
              state_next = S_FRD;
            end
            aisbit_pkg::OP_CLEAR: begin
              cmd.clear  = 1'b1;
              state_next = S_RESULT;
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end
      S_RD_CUR: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_partial = 1'b1;
        state_next       = S_PUT;
      end
      S_PUT: begin
        cmd.put       = 1'b1;
        cmd.crc_en    = is_add;
        cmd.zero_fill = !is_add;
        step_next     = step + STEP_W'(1);
        if (step == limit - STEP_W'(1)) begin
          state_next = S_RESULT;
        end
      end
      S_FRD: begin
        // read data is registered, so it arrives in the cycle after its address
        cmd.rd_field = 1'b1;
        cmd.win_load = (step != '0);
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(aisbit_pkg::WIN_BYTES - 1)) begin
          state_next = S_FLAST;
        end
      end
      S_FLAST: begin
        cmd.win_load = 1'b1;
        state_next   = S_FEXT;
      end
      S_FEXT: begin
        cmd.extract = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || m_tready) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      limit     <= '0;
      is_add    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      limit     <= limit_next;
      is_add    <= is_add_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted transaction not processed");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> m_tvalid)
    else $error("result loaded but not presented");

  a_put_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PUT |-> step < limit)
    else $error("bit step past limit");

  a_frd_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FRD |-> step < STEP_W'(aisbit_pkg::WIN_BYTES))
    else $error("field read past window");

endmodule

// ===== hw/rtl/ais_packet_bit_assembler_crc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ais_packet_bit_assembler_crc_unit
// Packet bit assembler with HDLC / X.25 CRC-16 frame check, APB config.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser operation, tdata operands
// m_*       out  m_tvalid/m_tready  status + field result, one per input
// apb       in   psel/penable       min_good_bits at byte address 0
//
// Steps per transaction (input accept to result load):
//   add byte   : read and load the partial byte, 8 bit-serial store+crc steps
//   add fill   : read and load the partial byte, one zero store step per fill bit;
//                straight to the result load when fill_count is 0
//   read field : 5 byte reads on the one store read port, last read data, extract
//   discard, clear, unknown op : straight to the result load
// One transaction is in work at a time; add byte is paced by its bit-serial
// store/crc steps. Result sits in an output register, so the next
// transaction is taken while it waits; only the result load stalls on m_tready.
// Reset: synchronous, active high; count 0, crc 0xFFFF, overflow 0,
// min_good_bits 64. Store contents are not cleared (reads are masked by count).
// ----------------------------------------------------------------------------
module ais_packet_bit_assembler_crc_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] data_byte, [15:8] fill_count, [25:16] field_pos, [31:26] field_count
  input  logic [aisbit_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [2:0] operation
  input  logic [aisbit_pkg::OP_W-1:0]         s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [10:0] bit_count, [26:11] crc_value, [27] crc_ok, [28] too_short,
  // [60:29] field_value, [66:61] message_type, [68:67] repeat_indicator,
  // [98:69] station_id, [99] overflow, [103:100] zero
  output logic [aisbit_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int MIN_W = aisbit_pkg::MIN_W;

  aisbit_pkg::aisbit_cmd_t cmd;
  logic [MIN_W-1:0]        min_good_bits;
  logic                    cfg_wr;

  // config register; a write lands on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_good_bits <= aisbit_pkg::MIN_GOOD_RESET;
    end else if (cfg_wr && paddr[2] == aisbit_pkg::REG_MIN_GOOD) begin
      min_good_bits <= pwdata[MIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == aisbit_pkg::REG_MIN_GOOD)
                  ? {(32 - MIN_W)'(0), min_good_bits} : 32'h0;

  aisbit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser),
    .fill     (s_tdata[15:8]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  aisbit_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .in_byte       (s_tdata[7:0]),
    .in_pos        (s_tdata[25:16]),
    .in_cnt        (s_tdata[31:26]),
    .min_good_bits (min_good_bits),
    .result_data   (m_tdata)
  );

endmodule
